>>> hw/rtl/frame_free_list_allocator_macros.svh
// Assertion helpers shared by the allocator RTL.
// Every property is sampled on the rising edge of clk and is off while rst is high.
`ifndef FRAME_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FRAME_FREE_LIST_ALLOCATOR_MACROS_SVH

// Checks a condition at every clock edge.
`define FFLA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a trigger at one edge is followed by a result at the next edge.
`define FFLA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/ffla_pkg.sv
package ffla_pkg;

  localparam int MAX_FRAMES = 1024;
  localparam int ADDR_W     = 48;
  localparam int IDX_W      = $clog2(MAX_FRAMES);
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int SHIFT_W    = 5;
  localparam int COUNT_W    = 8;
  localparam int FCOUNT_W   = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = ADDR_W;

  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [SHIFT_W-1:0]  shift_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [FCOUNT_W-1:0] fcount_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_ADDRESS = 2'd0,
    CFG_FRAME_SHIFT  = 2'd1,
    CFG_FRAME_COUNT  = 2'd2
  } cfg_reg_t;

  localparam logic KIND_ALLOC  = 1'b0;
  localparam logic KIND_FREE   = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  localparam addr_t   RST_BASE_ADDRESS = '0;
  localparam shift_t  RST_FRAME_SHIFT  = SHIFT_W'(12);
  localparam fcount_t RST_FRAME_COUNT  = FCOUNT_W'(1024);

endpackage

>>> hw/rtl/ffla_if.sv
interface ffla_req_if;
  logic                   valid;
  logic                   ready;
  logic                   kind;
  ffla_pkg::count_t       requested_count;
  ffla_pkg::addr_t        frame_address;

  modport source (output valid, output kind, output requested_count, output frame_address,
                  input ready);
  modport sink (input valid, input kind, input requested_count, input frame_address,
                output ready);
endinterface

interface ffla_rsp_if;
  logic                   valid;
  logic                   ready;
  logic                   status;
  ffla_pkg::addr_t        granted_address;

  modport source (output valid, output status, output granted_address, input ready);
  modport sink (input valid, input status, input granted_address, output ready);
endinterface

>>> hw/rtl/frame_free_list_allocator.sv
// Frame allocator for a pool of equal, power-of-two sized frames.
// Channel req carries one item per request: kind (allocate or free), requested_count
// and frame_address. Channel rsp returns exactly one item per request: status and
// granted_address. Both use valid/ready; an item moves when both are high.
// The configuration port (cfg_we, cfg_index, cfg_data) sets base_address, frame_shift
// and frame_count; write it only while no request is in flight.
// A request moves through states S_LOOK and S_DONE: the accepting edge reads the free
// ring, S_LOOK decodes the frame index and reads the allocated-mark memory, and S_DONE
// writes both memories back and loads the result register once that register is free.
// Ready returns as that result becomes valid, so the block holds one request at a time
// and takes a new request only after the last result is loaded, as set by this
// read-modify-write sequence on the two single-port memories.
// Reset clears the ring pointers, the fill and fresh counters and the state and valid
// registers; no clearing pass is needed: marks past the fresh counter read as clear.
// If the receiver stalls, the finished result waits in the output register; a new
// request is still accepted, and its own result waits until the register is free.
`include "frame_free_list_allocator_macros.svh"

module frame_free_list_allocator (
  input  logic                                 clk,
  input  logic                                 rst,
  ffla_req_if.sink                             req,
  ffla_rsp_if.source                           rsp,
  input  logic                                 cfg_we,
  input  logic [ffla_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ffla_pkg::CFG_DATA_W-1:0]      cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_DONE
  } state_t;

  state_t state;

  ffla_pkg::addr_t   base_address;
  ffla_pkg::shift_t  frame_shift;
  ffla_pkg::fcount_t frame_count;

  ffla_pkg::idx_t ring_head;
  ffla_pkg::idx_t ring_tail;
  ffla_pkg::cnt_t ring_fill;
  ffla_pkg::cnt_t next_fresh_frame;

  ffla_pkg::idx_t free_ring [ffla_pkg::MAX_FRAMES];
  logic           allocated_marks [ffla_pkg::MAX_FRAMES];

  ffla_pkg::idx_t ring_rdata;
  logic           mark_rdata;

  logic            kind_q;
  logic            count_ok_q;
  ffla_pkg::addr_t offset_q;
  ffla_pkg::idx_t  idx_q;
  logic            cand_ok_q;
  logic            fresh_q;
  logic            mark_live_q;
  ffla_pkg::addr_t grant_q;

  logic            rsp_valid;
  logic            rsp_status;
  ffla_pkg::addr_t rsp_granted;

  logic            req_fire;
  ffla_pkg::cnt_t  pool_limit;
  ffla_pkg::addr_t low_mask;
  ffla_pkg::addr_t idx_wide;
  logic            aligned;
  logic            in_pool;
  logic            use_fresh;
  logic            use_ring;
  ffla_pkg::idx_t  idx_sel;
  logic            cand_ok;
  ffla_pkg::addr_t grant_addr;
  logic            done_fire;
  logic            free_ok;
  logic            alloc_ok;
  logic            ring_we;
  logic            mark_we;
  ffla_pkg::idx_t  ring_head_inc;
  ffla_pkg::idx_t  ring_tail_inc;
  logic            fill_in_step;
  logic            counts_in_range;

  assign req.ready      = (state == S_IDLE) && !rst;
  assign req_fire       = req.valid && req.ready;
  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_status;
  assign rsp.granted_address = rsp_granted;

  // Counts above the ring capacity behave as a full-size pool.
  assign pool_limit = (frame_count > ffla_pkg::FCOUNT_W'(ffla_pkg::MAX_FRAMES))
                      ? ffla_pkg::CNT_W'(ffla_pkg::MAX_FRAMES)
                      : ffla_pkg::CNT_W'(frame_count);

  always_comb begin
    low_mask  = ~({ffla_pkg::ADDR_W{1'b1}} << frame_shift);
    idx_wide  = offset_q >> frame_shift;
    aligned   = (offset_q & low_mask) == '0;
    in_pool   = idx_wide < ffla_pkg::ADDR_W'(pool_limit);
    use_fresh = next_fresh_frame < pool_limit;
    use_ring  = ring_fill != '0;
    if (kind_q == ffla_pkg::KIND_FREE) begin
      idx_sel = idx_wide[ffla_pkg::IDX_W-1:0];
      cand_ok = count_ok_q && aligned && in_pool;
    end else begin
      idx_sel = use_fresh ? next_fresh_frame[ffla_pkg::IDX_W-1:0] : ring_rdata;
      cand_ok = count_ok_q && (use_fresh || use_ring);
    end
    grant_addr = base_address + (ffla_pkg::ADDR_W'(idx_sel) << frame_shift);
  end

  always_comb begin
    done_fire = (state == S_DONE) && (!rsp_valid || rsp.ready);
    // A mark at or beyond the fresh counter was never written since reset.
    free_ok   = cand_ok_q && mark_rdata && mark_live_q
                && (ring_fill != ffla_pkg::CNT_W'(ffla_pkg::MAX_FRAMES));
    alloc_ok  = cand_ok_q;
    ring_we   = done_fire && (kind_q == ffla_pkg::KIND_FREE) && free_ok;
    mark_we   = done_fire && (((kind_q == ffla_pkg::KIND_FREE) && free_ok)
                              || ((kind_q == ffla_pkg::KIND_ALLOC) && alloc_ok));
    ring_head_inc = (ring_head == ffla_pkg::IDX_W'(ffla_pkg::MAX_FRAMES - 1))
                    ? '0 : ring_head + 1'b1;
    ring_tail_inc = (ring_tail == ffla_pkg::IDX_W'(ffla_pkg::MAX_FRAMES - 1))
                    ? '0 : ring_tail + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      ring_rdata <= free_ring[ring_head];
    end
    if (ring_we) begin
      free_ring[ring_tail] <= idx_q;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LOOK) begin
      mark_rdata <= allocated_marks[idx_sel];
    end
    if (mark_we) begin
      allocated_marks[idx_q] <= (kind_q == ffla_pkg::KIND_ALLOC);
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      kind_q     <= req.kind;
      count_ok_q <= req.requested_count <= ffla_pkg::COUNT_W'(1);
      offset_q   <= req.frame_address - base_address;
    end
    if (state == S_LOOK) begin
      idx_q       <= idx_sel;
      cand_ok_q   <= cand_ok;
      fresh_q     <= use_fresh;
      mark_live_q <= ffla_pkg::CNT_W'(idx_sel) < next_fresh_frame;
      grant_q     <= grant_addr;
    end
    if (done_fire) begin
      if (kind_q == ffla_pkg::KIND_FREE) begin
        rsp_status  <= free_ok ? ffla_pkg::STATUS_OK : ffla_pkg::STATUS_FAIL;
        rsp_granted <= '0;
      end else begin
        rsp_status  <= alloc_ok ? ffla_pkg::STATUS_OK : ffla_pkg::STATUS_FAIL;
        rsp_granted <= alloc_ok ? grant_q : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      base_address     <= ffla_pkg::RST_BASE_ADDRESS;
      frame_shift      <= ffla_pkg::RST_FRAME_SHIFT;
      frame_count      <= ffla_pkg::RST_FRAME_COUNT;
      ring_head        <= '0;
      ring_tail        <= '0;
      ring_fill        <= '0;
      next_fresh_frame <= '0;
      rsp_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ffla_pkg::CFG_BASE_ADDRESS: base_address <= cfg_data;
          ffla_pkg::CFG_FRAME_SHIFT:  frame_shift  <= cfg_data[ffla_pkg::SHIFT_W-1:0];
          ffla_pkg::CFG_FRAME_COUNT:  frame_count  <= cfg_data[ffla_pkg::FCOUNT_W-1:0];
          default: ;
        endcase
      end

      // A new result replaces one that leaves in the same cycle.
      if (done_fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (done_fire) begin
            state <= S_IDLE;
            if (kind_q == ffla_pkg::KIND_FREE) begin
              if (free_ok) begin
                ring_tail <= ring_tail_inc;
                ring_fill <= ring_fill + 1'b1;
              end
            end else if (alloc_ok) begin
              if (fresh_q) begin
                next_fresh_frame <= next_fresh_frame + 1'b1;
              end else begin
                ring_head <= ring_head_inc;
                ring_fill <= ring_fill - 1'b1;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The fill count must track the distance between the ring pointers.
  assign fill_in_step    = ring_fill[ffla_pkg::IDX_W-1:0]
                           == ffla_pkg::IDX_W'(ring_tail - ring_head);
  assign counts_in_range = (ring_fill <= ffla_pkg::CNT_W'(ffla_pkg::MAX_FRAMES))
                           && (next_fresh_frame <= ffla_pkg::CNT_W'(ffla_pkg::MAX_FRAMES));

  `FFLA_ASSERT(a_fill_matches_ptrs, fill_in_step, "ring fill disagrees with ring pointers")
  `FFLA_ASSERT(a_counts_bounded, counts_in_range, "fill or fresh counter beyond capacity")
  `FFLA_ASSERT_NEXT(a_one_in_flight, req_fire, !req.ready, "item accepted while one in flight")

endmodule

>>> bench/tb_frame_free_list_allocator.sv
`timescale 1ns / 1ps

module tb_frame_free_list_allocator;

  // Index 3 has no register behind it; writes to it must change nothing.
  localparam logic [ffla_pkg::CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 222;
  localparam ffla_pkg::addr_t ADDR_ALL_ONES = '1;

  typedef struct packed {
    logic            status;
    ffla_pkg::addr_t granted_address;
  } answer_t;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_we;
  logic [ffla_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ffla_pkg::CFG_DATA_W-1:0] cfg_data;

  ffla_req_if req_ch();
  ffla_rsp_if rsp_ch();

  frame_free_list_allocator u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Shadow copy of the allocator: configuration, returned-frame ring and marks.
  ffla_pkg::addr_t   pool_base;
  ffla_pkg::shift_t  pool_shift;
  ffla_pkg::fcount_t pool_frames;
  ffla_pkg::idx_t    returned_ring [ffla_pkg::MAX_FRAMES];
  ffla_pkg::idx_t    ring_rd;
  ffla_pkg::idx_t    ring_wr;
  ffla_pkg::cnt_t    ring_used;
  ffla_pkg::cnt_t    fresh_next;
  logic              frame_taken [ffla_pkg::MAX_FRAMES];
  ffla_pkg::idx_t    held_frames [$];
  answer_t           awaited_answers [$];

  int error_count = 0;
  int idle_cycles = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  function automatic void clear_pool_state();
    pool_base   = ffla_pkg::RST_BASE_ADDRESS;
    pool_shift  = ffla_pkg::RST_FRAME_SHIFT;
    pool_frames = ffla_pkg::RST_FRAME_COUNT;
    ring_rd     = '0;
    ring_wr     = '0;
    ring_used   = '0;
    fresh_next  = '0;
    foreach (frame_taken[i]) frame_taken[i] = 1'b0;
    held_frames.delete();
  endfunction

  function automatic ffla_pkg::cnt_t pool_limit();
    return (pool_frames > ffla_pkg::MAX_FRAMES) ? ffla_pkg::cnt_t'(ffla_pkg::MAX_FRAMES)
                                                : ffla_pkg::cnt_t'(pool_frames);
  endfunction

  function automatic ffla_pkg::addr_t frame_address_of(ffla_pkg::idx_t idx);
    return ffla_pkg::addr_t'(pool_base + (64'(idx) << pool_shift));
  endfunction

  function automatic logic can_allocate();
    return (fresh_next < pool_limit()) || (ring_used != 0);
  endfunction

  // Applies one request to the shadow state and returns the answer it must get.
  function automatic answer_t serve_request(logic kind, ffla_pkg::count_t count,
                                            ffla_pkg::addr_t addr);
    answer_t        ans;
    logic [63:0]    offset;
    logic [63:0]    index;
    ffla_pkg::idx_t idx;
    int             hits [$];
    ans.status          = ffla_pkg::STATUS_FAIL;
    ans.granted_address = '0;
    if (count <= 1) begin
      if (kind == ffla_pkg::KIND_ALLOC) begin
        if (can_allocate()) begin
          // Frames never handed out go first, then the oldest returned one.
          if (fresh_next < pool_limit()) begin
            idx = ffla_pkg::idx_t'(fresh_next);
            fresh_next++;
          end else begin
            idx = returned_ring[ring_rd];
            ring_rd++;
            ring_used--;
          end
          frame_taken[idx] = 1'b1;
          held_frames.insert(held_frames.size(), idx);
          ans.status          = ffla_pkg::STATUS_OK;
          ans.granted_address = frame_address_of(idx);
        end
      end else begin
        // Alignment and range are judged on the distance from the base.
        offset = 64'(ffla_pkg::addr_t'(addr - pool_base));
        index  = offset >> pool_shift;
        if ((offset & ((64'd1 << pool_shift) - 64'd1)) == 0 && index < pool_limit()
            && frame_taken[index[ffla_pkg::IDX_W-1:0]]
            && ring_used < ffla_pkg::MAX_FRAMES) begin
          idx = index[ffla_pkg::IDX_W-1:0];
          frame_taken[idx]       = 1'b0;
          returned_ring[ring_wr] = idx;
          ring_wr++;
          ring_used++;
          hits = held_frames.find_first_index(x) with (x == idx);
          if (hits.size() != 0) held_frames.delete(hits[0]);
          ans.status = ffla_pkg::STATUS_OK;
        end
      end
    end
    return ans;
  endfunction

  task automatic wait_until_idle();
    req_ch.valid <= 1'b0;
    while (awaited_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [ffla_pkg::CFG_IDX_W-1:0] index,
                           logic [ffla_pkg::CFG_DATA_W-1:0] data);
    wait_until_idle();
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      ffla_pkg::CFG_BASE_ADDRESS: pool_base = data;
      ffla_pkg::CFG_FRAME_SHIFT:  pool_shift = data[ffla_pkg::SHIFT_W-1:0];
      ffla_pkg::CFG_FRAME_COUNT:  pool_frames = data[ffla_pkg::FCOUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_request(logic kind, ffla_pkg::count_t count, ffla_pkg::addr_t addr);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.kind            <= kind;
    req_ch.requested_count <= count;
    req_ch.frame_address   <= addr;
    do @(posedge clk); while (!req_ch.ready);
    awaited_answers.insert(awaited_answers.size(), serve_request(kind, count, addr));
  endtask

  task automatic test_request_counts();
    send_request(ffla_pkg::KIND_ALLOC, 8'd0, ffla_pkg::addr_t'({$urandom(), $urandom()}));
    send_request(ffla_pkg::KIND_ALLOC, 8'd1, ADDR_ALL_ONES);
    send_request(ffla_pkg::KIND_ALLOC, 8'd2, '0);
    send_request(ffla_pkg::KIND_ALLOC, 8'd255, '0);
    send_request(ffla_pkg::KIND_FREE, 8'd2, frame_address_of(ffla_pkg::idx_t'(0)));
    send_request(ffla_pkg::KIND_FREE, 8'd255, frame_address_of(ffla_pkg::idx_t'(1)));
  endtask

  task automatic test_free_checks();
    send_request(ffla_pkg::KIND_FREE, 8'd1, frame_address_of(ffla_pkg::idx_t'(0)));
    send_request(ffla_pkg::KIND_FREE, 8'd1, frame_address_of(ffla_pkg::idx_t'(0)));
    send_request(ffla_pkg::KIND_FREE, 8'd1,
                 frame_address_of(ffla_pkg::idx_t'(1)) + ffla_pkg::addr_t'(8));
    send_request(ffla_pkg::KIND_FREE, 8'd1, ffla_pkg::addr_t'(64'd1024 << pool_shift));
    send_request(ffla_pkg::KIND_FREE, 8'd1, ADDR_ALL_ONES);
    send_request(ffla_pkg::KIND_FREE, 8'd0, frame_address_of(ffla_pkg::idx_t'(1)));
  endtask

  // Returned frames above a shrunk pool are still issued but cannot come back.
  task automatic test_shrunk_pool();
    write_reg(ffla_pkg::CFG_FRAME_COUNT, 48'd1);
    send_request(ffla_pkg::KIND_ALLOC, 8'd1, '0);
    send_request(ffla_pkg::KIND_ALLOC, 8'd0, '0);
    send_request(ffla_pkg::KIND_ALLOC, 8'd1, '0);
    send_request(ffla_pkg::KIND_FREE, 8'd1, frame_address_of(ffla_pkg::idx_t'(1)));
    send_request(ffla_pkg::KIND_FREE, 8'd1, frame_address_of(ffla_pkg::idx_t'(0)));
    write_reg(ffla_pkg::CFG_FRAME_COUNT, 48'd0);
    send_request(ffla_pkg::KIND_ALLOC, 8'd1, '0);
    send_request(ffla_pkg::KIND_ALLOC, 8'd1, '0);
  endtask

  task automatic test_unaligned_base();
    write_reg(ffla_pkg::CFG_BASE_ADDRESS, 48'hFFFF_FFFF_FE05);
    write_reg(ffla_pkg::CFG_FRAME_SHIFT, 48'd10);
    write_reg(ffla_pkg::CFG_FRAME_COUNT, 48'd2047);
    send_request(ffla_pkg::KIND_ALLOC, 8'd1, '0);
    send_request(ffla_pkg::KIND_FREE, 8'd1, frame_address_of(ffla_pkg::idx_t'(2)));
    send_request(ffla_pkg::KIND_FREE, 8'd1, pool_base + ffla_pkg::addr_t'(1));
    write_reg(ffla_pkg::CFG_FRAME_SHIFT, 48'd30);
    send_request(ffla_pkg::KIND_ALLOC, 8'd1, '0);
    send_request(ffla_pkg::KIND_FREE, 8'd1, frame_address_of(ffla_pkg::idx_t'(3)));
    write_reg(CFG_SPARE_INDEX, ffla_pkg::CFG_DATA_W'({$urandom(), $urandom()}));
    send_request(ffla_pkg::KIND_ALLOC, 8'd0, '0);
  endtask

  task automatic send_random_request();
    int               pick;
    logic [63:0]      raw;
    ffla_pkg::count_t count;
    ffla_pkg::addr_t  addr;
    ffla_pkg::idx_t   usable [$];
    pick   = $urandom_range(0, 99);
    raw    = {$urandom(), $urandom()};
    count  = ffla_pkg::count_t'($urandom_range(0, 1));
    usable = held_frames.find(x) with (x < pool_limit());
    if (pick < 10) begin
      case ($urandom_range(0, 4))
        0: send_request(raw[48], ffla_pkg::count_t'($urandom_range(2, 255)), raw[47:0]);
        1: send_request(ffla_pkg::KIND_FREE, count, raw[47:0]);
        2: begin
          // A held frame's address with some low bits set, usually misaligned.
          addr = (held_frames.size() != 0) ?
                 frame_address_of(held_frames[$urandom_range(0, held_frames.size() - 1)]) :
                 raw[47:0];
          send_request(ffla_pkg::KIND_FREE, count,
                       addr + ffla_pkg::addr_t'(raw & ((64'd1 << pool_shift) - 64'd1)));
        end
        3: send_request(ffla_pkg::KIND_FREE, count,
                        frame_address_of(ffla_pkg::idx_t'($urandom_range(0, 1023))));
        default: send_request(raw[48], ffla_pkg::count_t'(raw[56:49]), raw[47:0]);
      endcase
    end else if (usable.size() == 0 || (can_allocate() && $urandom_range(0, 1) == 1)) begin
      send_request(ffla_pkg::KIND_ALLOC, count, raw[47:0]);
    end else begin
      send_request(ffla_pkg::KIND_FREE, count,
                   frame_address_of(usable[$urandom_range(0, usable.size() - 1)]));
    end
  endtask

  task automatic test_random_traffic();
    logic [63:0]     raw;
    ffla_pkg::addr_t base_sel;
    int              shift_sel;
    int              count_sel;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      raw = {$urandom(), $urandom()};
      case (phase)
        0: begin base_sel = '0;            shift_sel = 12; count_sel = 8;    end
        1: begin base_sel = raw[47:0];     shift_sel = 10; count_sel = 16;   end
        2: begin base_sel = raw[47:0];     shift_sel = 30; count_sel = 1;    end
        3: begin base_sel = ADDR_ALL_ONES; shift_sel = 31; count_sel = 3;    end
        4: begin base_sel = raw[47:0];     shift_sel = 0;  count_sel = 32;   end
        5: begin base_sel = raw[47:0];     shift_sel = 20; count_sel = 12;   end
        6: begin base_sel = raw[47:0];     shift_sel = 11; count_sel = 2047; end
        default: begin base_sel = raw[47:0]; shift_sel = 16; count_sel = 1024; end
      endcase
      raw = {$urandom(), $urandom()};
      // Odd phases put junk above the used bits of the narrow registers.
      if (phase % 2 == 0) raw = '0;
      write_reg(ffla_pkg::CFG_BASE_ADDRESS, base_sel);
      write_reg(ffla_pkg::CFG_FRAME_SHIFT,
                {raw[47:ffla_pkg::SHIFT_W], ffla_pkg::shift_t'(shift_sel)});
      write_reg(ffla_pkg::CFG_FRAME_COUNT,
                {raw[47:ffla_pkg::FCOUNT_W], ffla_pkg::fcount_t'(count_sel)});
      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 62; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 62; end
        default: begin sender_idle_pct = 16; receiver_stall_pct = 16; end
      endcase
      repeat (PHASE_ITEMS) send_random_request();
    end
  endtask

  always @(posedge clk) begin : check_answers
    answer_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_answers.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d address %h",
                 $time, rsp_ch.status, rsp_ch.granted_address);
        error_count++;
      end else begin
        want = awaited_answers[0];
        awaited_answers.delete(0);
        if (rsp_ch.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, want.status, rsp_ch.status);
          error_count++;
        end
        if (rsp_ch.granted_address !== want.granted_address) begin
          $display("%0t: granted_address mismatch, expected %h actual %h",
                   $time, want.granted_address, rsp_ch.granted_address);
          error_count++;
        end
      end
    end
    rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
      $display("tb_frame_free_list_allocator failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst                    <= 1'b1;
    cfg_we                 <= 1'b0;
    cfg_index              <= ffla_pkg::CFG_BASE_ADDRESS;
    cfg_data               <= '0;
    req_ch.valid           <= 1'b0;
    req_ch.kind            <= ffla_pkg::KIND_ALLOC;
    req_ch.requested_count <= '0;
    req_ch.frame_address   <= '0;
    clear_pool_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_request_counts();
    test_free_checks();
    test_shrunk_pool();
    test_unaligned_base();
    test_random_traffic();
    wait_until_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && awaited_answers.size() == 0) begin
      $display("tb_frame_free_list_allocator passed");
    end else begin
      if (awaited_answers.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, awaited_answers.size());
      $display("tb_frame_free_list_allocator failed");
    end
    $finish;
  end

endmodule
